@@ design/ssa_pkg.sv @@
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared types, codes and widths of the spectrum sweep assembler.
// ----------------------------------------------------------------------------
package ssa_pkg;

  // Default sizes, handed to the top level as parameter defaults
  localparam int MaxSlotsDef    = 256;
  localparam int ReportBytesDef = 54;

  // Field widths
  localparam int FreqW   = 32;
  localparam int LengthW = 9;
  localparam int CountW  = 6;
  localparam int SampleW = 8;
  localparam int SlotW   = 8;
  localparam int CntW    = 16;
  // Running position: sweep length (at most 511) plus one report (at most 63)
  localparam int PosW    = 10;

  // Configuration port
  localparam int PaddrW  = 3;
  localparam int PdataW  = 32;

  typedef enum logic [0:0] {
    REG_SWEEP_START  = 1'b0,
    REG_SWEEP_LENGTH = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_HEADER = 2'd0,
    OP_DATA   = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_DISCARD  = 2'd1,
    ST_COMPLETE = 2'd2,
    ST_READ     = 2'd3
  } status_e;

endpackage

@@ design/ssa_in_if.sv @@
// ----------------------------------------------------------------------------
// ssa_in_if
// Input channel: report headers, sample bytes and slot reads.
// ----------------------------------------------------------------------------
interface ssa_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   operation;
  logic [ssa_pkg::FreqW-1:0]    report_start_khz;
  logic [ssa_pkg::CountW-1:0]   report_byte_count;
  logic [ssa_pkg::SampleW-1:0]  sample_value;
  logic [ssa_pkg::SlotW-1:0]    read_slot;

  modport source (
    output valid, operation, report_start_khz, report_byte_count, sample_value,
           read_slot,
    input  ready
  );

  modport sink (
    input  valid, operation, report_start_khz, report_byte_count, sample_value,
           read_slot,
    output ready
  );
endinterface

@@ design/ssa_out_if.sv @@
// ----------------------------------------------------------------------------
// ssa_out_if
// Output channel: one status result per input transfer.
// ----------------------------------------------------------------------------
interface ssa_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [ssa_pkg::SampleW-1:0]  read_value;
  logic [ssa_pkg::SampleW-1:0]  lowest_sample;
  logic [ssa_pkg::CntW-1:0]     sweeps_started;

  modport source (
    output valid, status, read_value, lowest_sample, sweeps_started,
    input  ready
  );

  modport sink (
    input  valid, status, read_value, lowest_sample, sweeps_started,
    output ready
  );
endinterface

@@ design/spectrum_sweep_assembler.sv @@
// ----------------------------------------------------------------------------
// spectrum_sweep_assembler
// Builds sweeps from spectrum sample reports in a slot memory and answers
// slot reads.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | carries
//  ---------+-----------+----------------------+-------------------------------
//  in_i     | in        | valid/ready          | header, sample byte or read
//  out_o    | out       | valid/ready          | status, read data, min, count
//  apb      | in        | psel/penable, pready | sweep start, sweep length
//
//  One item per cycle unless stalled: every transfer is decoded and committed
//  in the cycle it is taken; the slot memory's single write port and
//  registered read port are each used at most once per item. The result is
//  registered. The output register holds a stalled result; a new input
//  transfer is taken whenever that register is empty or being emptied in the
//  same cycle. Reset clears all control state; the slot memory is not
//  cleared, and a slot that was never written reads back an unspecified value.
// ----------------------------------------------------------------------------
module spectrum_sweep_assembler #(
  parameter int MAX_SLOTS    = ssa_pkg::MaxSlotsDef,
  parameter int REPORT_BYTES = ssa_pkg::ReportBytesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,

  ssa_in_if.sink                      in_i,
  ssa_out_if.source                   out_o,

  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssa_pkg::PaddrW-1:0]  paddr,
  input  logic [ssa_pkg::PdataW-1:0]  pwdata,
  output logic [ssa_pkg::PdataW-1:0]  prdata,
  output logic                        pready
);
  import ssa_pkg::*;

  localparam int AddrW = $clog2(MAX_SLOTS);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [FreqW-1:0]   sweep_start_q;
  logic [LengthW-1:0] sweep_length_q;
  logic               cfg_wr;
  reg_idx_e           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_start_q  <= FreqW'(32'd2399938);
      sweep_length_q <= LengthW'(9'd256);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SWEEP_START:  sweep_start_q  <= pwdata;
        REG_SWEEP_LENGTH: sweep_length_q <= pwdata[LengthW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SWEEP_START:  prdata = sweep_start_q;
      REG_SWEEP_LENGTH: prdata = PdataW'(sweep_length_q);
      default:          prdata = '0;
    endcase
  end

  // Sweep length, limited to the slot memory
  logic [PosW-1:0] len_w;
  assign len_w = (32'(sweep_length_q) > 32'(MAX_SLOTS)) ? PosW'(MAX_SLOTS)
                                                         : PosW'(sweep_length_q);

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic out_valid_q;
  logic in_xfer;

  // Accept while the result register is empty or draining this cycle
  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign in_xfer    = in_i.valid & in_i.ready;

  // --------------------------------------------------------------------------
  // Assembly state
  // --------------------------------------------------------------------------
  logic [PosW-1:0]    running_q,   running_d;
  logic [LengthW-1:0] base_q,      base_d;
  logic               accepted_q,  accepted_d;
  logic [CountW-1:0]  remaining_q, remaining_d;
  logic [CountW-1:0]  offset_q,    offset_d;
  logic               begun_q,     begun_d;
  logic [SampleW-1:0] lowest_q,    lowest_d;
  logic [CntW-1:0]    counter_q,   counter_d;

  status_e            status_d;
  logic               wr_en;
  logic [AddrW-1:0]   wr_addr;
  logic               rd_en;
  logic               rd_ok_d;

  logic [CountW-1:0]  count_clip;
  logic [PosW-1:0]    hdr_base;
  logic [PosW-1:0]    slot;
  logic [PosW-1:0]    end_pos;

  assign count_clip = (32'(in_i.report_byte_count) > 32'(REPORT_BYTES))
                      ? CountW'(REPORT_BYTES) : in_i.report_byte_count;
  assign hdr_base   = (in_i.report_start_khz == sweep_start_q) ? '0 : running_q;
  assign slot       = PosW'(base_q) + PosW'(offset_q);
  assign end_pos    = PosW'(base_q) + PosW'(offset_q) + PosW'(1);
  assign wr_addr    = AddrW'(slot);

  always_comb begin
    running_d   = running_q;
    base_d      = base_q;
    accepted_d  = accepted_q;
    remaining_d = remaining_q;
    offset_d    = offset_q;
    begun_d     = begun_q;
    lowest_d    = lowest_q;
    counter_d   = counter_q;
    status_d    = ST_NONE;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    rd_ok_d     = 1'b0;

    case (op_e'(in_i.operation))
      OP_HEADER: begin
        // Abandon any open report
        accepted_d  = 1'b0;
        remaining_d = '0;
        offset_d    = '0;
        running_d   = hdr_base;
        if (hdr_base > len_w) begin
          status_d = ST_DISCARD;
        end else if (hdr_base != '0 && !begun_q) begin
          status_d = ST_DISCARD;
        end else begin
          if (hdr_base == '0) begin
            begun_d   = 1'b1;
            counter_d = counter_q + CntW'(1);
          end
          base_d    = LengthW'(hdr_base);
          running_d = hdr_base + PosW'(count_clip);
          if (count_clip == '0) begin
            if (hdr_base == len_w) begin
              status_d = ST_COMPLETE;
            end
          end else begin
            accepted_d  = 1'b1;
            remaining_d = count_clip;
          end
        end
      end
      OP_DATA: begin
        if (accepted_q && remaining_q != '0) begin
          if (slot < len_w) begin
            wr_en = 1'b1;
            if (in_i.sample_value < lowest_q) begin
              lowest_d = in_i.sample_value;
            end
          end
          offset_d    = offset_q + CountW'(1);
          remaining_d = remaining_q - CountW'(1);
          if (remaining_q == CountW'(1)) begin
            accepted_d = 1'b0;
            if (end_pos == len_w) begin
              status_d = ST_COMPLETE;
            end
          end
        end
      end
      OP_READ: begin
        status_d = ST_READ;
        rd_en    = 1'b1;
        rd_ok_d  = 32'(in_i.read_slot) < 32'(MAX_SLOTS);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= '0;
      base_q      <= '0;
      accepted_q  <= 1'b0;
      remaining_q <= '0;
      offset_q    <= '0;
      begun_q     <= 1'b0;
      lowest_q    <= '1;
      counter_q   <= '0;
    end else if (in_xfer) begin
      running_q   <= running_d;
      base_q      <= base_d;
      accepted_q  <= accepted_d;
      remaining_q <= remaining_d;
      offset_q    <= offset_d;
      begun_q     <= begun_d;
      lowest_q    <= lowest_d;
      counter_q   <= counter_d;
    end
  end

  // --------------------------------------------------------------------------
  // Slot memory: one write port, one registered read port. Write and read
  // come from different items, so a read always sees earlier writes.
  // --------------------------------------------------------------------------
  logic [SampleW-1:0] slot_mem [MAX_SLOTS];
  logic [SampleW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer && wr_en) begin
      slot_mem[wr_addr] <= in_i.sample_value;
    end
    if (in_xfer && rd_en) begin
      rd_data_q <= slot_mem[AddrW'(in_i.read_slot)];
    end
  end

  // --------------------------------------------------------------------------
  // Result register; minimum and sweep count are read straight from the state,
  // which only advances together with this register.
  // --------------------------------------------------------------------------
  status_e status_q;
  logic    rd_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      status_q    <= ST_NONE;
      rd_ok_q     <= 1'b0;
    end else begin
      if (in_xfer) begin
        out_valid_q <= 1'b1;
        status_q    <= status_d;
        rd_ok_q     <= rd_ok_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = status_q;
  assign out_o.read_value     = (status_q == ST_READ && rd_ok_q) ? rd_data_q : '0;
  assign out_o.lowest_sample  = lowest_q;
  assign out_o.sweeps_started = counter_q;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the spectrum sweep assembler. A shadow model follows
// every input transfer and queues the status it predicts. A sink process pulls
// results under random back-pressure and compares them field by field. A short
// directed run covers the corner cases. Random phases under changing sweep
// settings follow, with well-formed reports, broken reports, stray bytes and
// slot reads.
// ----------------------------------------------------------------------------
module tb;
  import ssa_pkg::*;

  // Opcode the block leaves unused; it must answer with an empty status
  localparam logic [1:0]        OP_UNUSED       = 2'd3;
  localparam logic [FreqW-1:0]  RESET_START_KHZ = 32'd2399938;
  localparam int                MAX_CYCLES      = 400000;
  // Long receiver hold-off, so that the output register fills and the input stalls
  localparam int                PRESSURE_AT     = 120;
  localparam int                PRESSURE_CYCLES = 300;

  typedef struct {
    logic [1:0]         op;
    logic [FreqW-1:0]   freq_khz;
    logic [CountW-1:0]  byte_count;
    logic [SampleW-1:0] sample_value;
    logic [SlotW-1:0]   slot;
  } ssa_item_t;

  typedef struct {
    logic [1:0]         status;
    logic [SampleW-1:0] read_value;
    logic [SampleW-1:0] lowest;
    logic [CntW-1:0]    sweeps;
  } ssa_result_t;

  // --------------------------------------------------------------------------
  // Shadow of the assembler: registers, sweep store, report tracking and the
  // queue of results still due from the block.
  // --------------------------------------------------------------------------
  class sweep_shadow;
    logic [FreqW-1:0]   freq_khz;
    logic [LengthW-1:0] sweep_len;
    logic [SampleW-1:0] slots [MaxSlotsDef];
    bit                 slot_written [MaxSlotsDef];
    int                 filled [$];
    logic [PosW-1:0]    run_pos;
    logic [PosW-1:0]    base;
    bit                 open_report;
    logic [CountW-1:0]  remaining;
    logic [CountW-1:0]  offset;
    bit                 begun;
    logic [SampleW-1:0] lowest;
    logic [CntW-1:0]    sweeps;
    ssa_result_t        due_results [$];
    int                 errors;

    function new();
      freq_khz    = RESET_START_KHZ;
      sweep_len   = LengthW'(MaxSlotsDef);
      run_pos     = '0;
      base        = '0;
      open_report = 1'b0;
      remaining   = '0;
      offset      = '0;
      begun       = 1'b0;
      lowest      = '1;
      sweeps      = '0;
      errors      = 0;
    endfunction

    function int active_len();
      return (int'(sweep_len) > MaxSlotsDef) ? MaxSlotsDef : int'(sweep_len);
    endfunction

    function void apply_register(reg_idx_e idx, logic [PdataW-1:0] value);
      case (idx)
        REG_SWEEP_START:  freq_khz  = value;
        REG_SWEEP_LENGTH: sweep_len = value[LengthW-1:0];
        default: ;
      endcase
    endfunction

    task report(string what);
      errors++;
      $display("ERROR at %0t: %s", $realtime, what);
    endtask

    // Returns 1 when the item does something, 0 when the block ignores it
    function bit note_item(ssa_item_t it);
      ssa_result_t r;
      int          len;
      int          cnt;
      int          at;
      bit          used;
      len          = active_len();
      cnt          = (int'(it.byte_count) > ReportBytesDef) ? ReportBytesDef
                                                            : int'(it.byte_count);
      r.status     = ST_NONE;
      r.read_value = '0;
      used         = 1'b0;
      case (it.op)
        OP_HEADER: begin
          used        = 1'b1;
          open_report = 1'b0;
          remaining   = '0;
          offset      = '0;
          if (it.freq_khz == freq_khz) run_pos = '0;
          if (int'(run_pos) > len) begin
            r.status = ST_DISCARD;
          end else if (run_pos != '0 && !begun) begin
            r.status = ST_DISCARD;
          end else begin
            if (run_pos == '0) begin
              begun  = 1'b1;
              sweeps = sweeps + CntW'(1);
            end
            base    = run_pos;
            run_pos = PosW'(int'(base) + cnt);
            if (cnt == 0) begin
              if (int'(base) == len) r.status = ST_COMPLETE;
            end else begin
              open_report = 1'b1;
              remaining   = CountW'(cnt);
            end
          end
        end
        OP_DATA: begin
          if (open_report && remaining != '0) begin
            used = 1'b1;
            at   = int'(base) + int'(offset);
            if (at < len) begin
              slots[at] = it.sample_value;
              if (!slot_written[at]) begin
                slot_written[at] = 1'b1;
                filled.push_back(at);
              end
              if (it.sample_value < lowest) lowest = it.sample_value;
            end
            offset++;
            remaining--;
            if (remaining == '0) begin
              open_report = 1'b0;
              if (int'(base) + int'(offset) == len) r.status = ST_COMPLETE;
            end
          end
        end
        OP_READ: begin
          used         = 1'b1;
          r.status     = ST_READ;
          r.read_value = slots[it.slot];
        end
        default: ;
      endcase
      r.lowest = lowest;
      r.sweeps = sweeps;
      due_results.push_back(r);
      return used;
    endfunction

    task check_result(ssa_result_t got);
      ssa_result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result, status %0d", got.status));
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status)
        report($sformatf("status: got %0d, want %0d", got.status, want.status));
      if (got.read_value !== want.read_value)
        report($sformatf("read_value: got %0d, want %0d", got.read_value, want.read_value));
      if (got.lowest !== want.lowest)
        report($sformatf("lowest_sample: got %0d, want %0d", got.lowest, want.lowest));
      if (got.sweeps !== want.sweeps)
        report($sformatf("sweeps_started: got %0d, want %0d", got.sweeps, want.sweeps));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  ssa_in_if  in_if ();
  ssa_out_if out_if ();

  spectrum_sweep_assembler dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  sweep_shadow sb = new();

  // Set while the sender holds valid high for the next transfer
  bit in_held;
  // Transfers that the block acted on (ignored bytes and spare opcodes excluded)
  int effective_items;
  // Sender's current run of back-to-back transfers
  int send_steady;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Fill the fields an operation does not use with random values
  function automatic ssa_item_t random_item(logic [1:0] op);
    ssa_item_t it;
    it.op           = op;
    it.freq_khz     = $urandom;
    it.byte_count   = CountW'($urandom_range(0, 63));
    it.sample_value = SampleW'($urandom_range(0, 255));
    it.slot         = SlotW'($urandom_range(0, 255));
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Input side. Every task starts and ends on a rising edge; valid is raised
  // or lowered at most once per edge.
  // --------------------------------------------------------------------------
  task automatic send_item(input ssa_item_t it);
    int gap;
    in_if.valid             <= 1'b1;
    in_if.operation         <= it.op;
    in_if.report_start_khz  <= it.freq_khz;
    in_if.report_byte_count <= it.byte_count;
    in_if.sample_value      <= it.sample_value;
    in_if.read_slot         <= it.slot;
    in_held = 1'b1;
    // Hold the item until the block takes the transfer
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    if (sb.note_item(it)) effective_items++;
    if (send_steady > 0) begin
      send_steady--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 49) == 0) send_steady = 40;
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      in_held = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_header(input logic [FreqW-1:0] freq_khz, input int count);
    ssa_item_t it;
    it            = random_item(OP_HEADER);
    it.freq_khz   = freq_khz;
    it.byte_count = count[CountW-1:0];
    send_item(it);
  endtask

  task automatic send_sample(input logic [SampleW-1:0] value);
    ssa_item_t it;
    it              = random_item(OP_DATA);
    it.sample_value = value;
    send_item(it);
  endtask

  task automatic send_read(input int slot);
    ssa_item_t it;
    it      = random_item(OP_READ);
    it.slot = slot[SlotW-1:0];
    send_item(it);
  endtask

  // Read back a slot that has been written since reset
  task automatic send_written_read();
    send_read(sb.filled[$urandom_range(0, sb.filled.size() - 1)]);
  endtask

  // Drop valid, then wait until every due result has been pulled
  task automatic wait_idle();
    if (in_held) begin
      in_if.valid <= 1'b0;
      in_held = 1'b0;
    end
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Write a register over the configuration port, then read it back
  task automatic set_register(input reg_idx_e idx, input logic [PdataW-1:0] value);
    logic [PdataW-1:0] want;
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    sb.apply_register(idx, value);
    // Turn the same selection round into a read
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    want = (idx == REG_SWEEP_LENGTH) ? PdataW'(value[LengthW-1:0]) : value;
    if (prdata !== want)
      sb.report($sformatf("register %0d read back %0h, want %0h", idx, prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Random traffic: mostly whole reports that follow the sweep, with exact
  // fills, overshoots, restarts and cut-short reports; stray bytes, spare
  // opcodes and slot reads mixed in.
  // --------------------------------------------------------------------------
  task automatic run_random(input int budget);
    int               first;
    int               roll;
    int               len;
    int               rem;
    int               cnt;
    int               nsend;
    int               upper;
    bit               restart;
    logic [FreqW-1:0] freq_khz;
    first = effective_items;
    while (effective_items - first < budget) begin
      roll = $urandom_range(0, 99);
      len  = sb.active_len();
      if (roll < 5) begin
        send_item(random_item(OP_DATA));
      end else if (roll < 8) begin
        send_item(random_item(OP_UNUSED));
      end else if (roll < 16 && sb.filled.size() > 0) begin
        send_written_read();
      end else begin
        rem = len - int'(sb.run_pos);
        // Restart within a sweep only on short sweeps, so long ones run to the end
        if (rem <= 0) restart = ($urandom_range(0, 1) == 0);
        else          restart = (len <= 64) && ($urandom_range(0, 9) == 0);
        if (restart) begin
          freq_khz = sb.freq_khz;
          rem      = len;
        end else begin
          freq_khz = $urandom;
          if (freq_khz == sb.freq_khz) freq_khz = freq_khz + FreqW'(1);
        end
        upper = (rem < 1) ? 1 : ((rem > ReportBytesDef) ? ReportBytesDef : rem);
        if (rem > 0 && rem <= ReportBytesDef && $urandom_range(0, 1) == 1) cnt = rem;
        else if ($urandom_range(0, 6) == 0)                               cnt = $urandom_range(0, 63);
        else                                                              cnt = $urandom_range(0, upper);
        send_header(freq_khz, cnt);
        nsend = (cnt > ReportBytesDef) ? ReportBytesDef : cnt;
        // Cut the odd report short; the next header abandons it
        if (nsend > 0 && $urandom_range(0, 9) == 0) nsend = $urandom_range(0, nsend - 1);
        repeat (nsend) begin
          if ($urandom_range(0, 29) == 0 && sb.filled.size() > 0) send_written_read();
          send_sample(SampleW'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result sink: check every transfer, stall at random, and once hold off
  // for a long stretch while the sender keeps offering.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    ssa_result_t got;
    int          stall_left;
    int          steady_left;
    int          results;
    bit          pressed;
    stall_left   = 0;
    steady_left  = 0;
    results      = 0;
    pressed      = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        got.status     = out_if.status;
        got.read_value = out_if.read_value;
        got.lowest     = out_if.lowest_sample;
        got.sweeps     = out_if.sweeps_started;
        sb.check_result(got);
        results++;
      end
      if (results == PRESSURE_AT && !pressed) begin
        pressed    = 1'b1;
        stall_left = PRESSURE_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (steady_left > 0) begin
        steady_left--;
        out_if.ready <= 1'b1;
      end else begin
        if ($urandom_range(0, 49) == 0) steady_left = 40;
        stall_left = pick_gap();
        if (stall_left > 0) begin
          stall_left--;
          out_if.ready <= 1'b0;
        end else begin
          out_if.ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: give up well past the slowest correct run
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles <= MAX_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    ssa_item_t spare;
    in_held         = 1'b0;
    effective_items = 0;
    send_steady     = 0;
    rst_ni                  <= 1'b0;
    psel                    <= 1'b0;
    penable                 <= 1'b0;
    pwrite                  <= 1'b0;
    paddr                   <= '0;
    pwdata                  <= '0;
    in_if.valid             <= 1'b0;
    in_if.operation         <= OP_HEADER;
    in_if.report_start_khz  <= '0;
    in_if.report_byte_count <= '0;
    in_if.sample_value      <= '0;
    in_if.read_slot         <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: a stray byte and a spare opcode before any sweep
    send_sample(8'h00);
    spare.op           = OP_UNUSED;
    spare.freq_khz     = '1;
    spare.byte_count   = '1;
    spare.sample_value = '1;
    spare.slot         = '1;
    send_item(spare);
    // Begin a sweep on the matching start and fill two slots
    send_header(RESET_START_KHZ, 2);
    send_sample(8'd200);
    send_sample(8'd255);
    send_read(0);
    send_read(1);

    // Three-slot sweep: continue, complete on the last byte and on an empty header
    set_register(REG_SWEEP_START, 32'hFFFF_FFFF);
    set_register(REG_SWEEP_LENGTH, 32'd3);
    send_header(32'd0, 1);
    send_sample(8'h80);
    send_header(32'd0, 0);
    // Oversized count clamps; its byte lands past the end and leaves the minimum alone
    send_header(32'd5, 63);
    send_sample(8'd1);
    // Base now beyond the sweep: discard, and ignore the byte that follows
    send_header(32'd7, 1);
    send_sample(8'd9);
    // Abandon an open report with a fresh header, then fill exactly
    send_header(32'hFFFF_FFFF, 54);
    send_sample(8'h55);
    send_header(32'hFFFF_FFFF, 3);
    send_sample(8'hAA);
    send_sample(8'h00);
    send_sample(8'hFE);
    send_read(2);

    // Empty sweep: an empty header completes at once, bytes go nowhere
    set_register(REG_SWEEP_START, 32'd0);
    set_register(REG_SWEEP_LENGTH, 32'd0);
    send_header(32'd0, 0);
    send_header(32'd0, 5);
    send_sample(8'd1);

    // Random phases over a spread of settings
    set_register(REG_SWEEP_START, $urandom);
    set_register(REG_SWEEP_LENGTH, MaxSlotsDef);
    run_random(280);
    set_register(REG_SWEEP_LENGTH, 32'd511);
    run_random(25);
    set_register(REG_SWEEP_START, 32'hFFFF_FFFF);
    set_register(REG_SWEEP_LENGTH, $urandom_range(2, 40));
    run_random(30);
    set_register(REG_SWEEP_START, 32'd0);
    set_register(REG_SWEEP_LENGTH, 32'd1);
    run_random(15);
    set_register(REG_SWEEP_LENGTH, $urandom_range(41, 120));
    run_random(25);
    set_register(REG_SWEEP_START, $urandom);
    set_register(REG_SWEEP_LENGTH, 32'd0);
    run_random(10);
    set_register(REG_SWEEP_LENGTH, $urandom_range(257, 511));
    run_random(25);

    // Drain, then watch a little longer for stray results
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ spectrum_sweep_assembler.f @@
design/ssa_pkg.sv
design/ssa_in_if.sv
design/ssa_out_if.sv
design/spectrum_sweep_assembler.sv
test/tb.sv
